FILE: hw/rtl/stg_pkg.sv
// Shared constants, types, tables and control structs for the sine tone generator.
package stg_pkg;

    localparam int SAMPLE_RATE = 16000;
    localparam int TABLE_BITS  = 8;
    localparam int TAB_N       = 1 << TABLE_BITS;
    localparam int FADE_LEN    = (SAMPLE_RATE / 200) > 0 ? (SAMPLE_RATE / 200) : 1;
    localparam int FADE_W      = (FADE_LEN > 1) ? $clog2(FADE_LEN) : 1;

    localparam int FIELD_W      = 16;
    localparam int IDX_W        = 22;
    localparam int PHASE_W      = 32;
    localparam int SINE_W       = 15;
    localparam int ENV_W        = 17;
    localparam int PROD_W       = 32;
    localparam int RECIP_W      = PROD_W + 1;
    localparam int RECIP_PROD_W = PROD_W + RECIP_W;
    localparam int MS_PER_S     = 1000;
    localparam int MS_SHIFT     = PROD_W + $clog2(MS_PER_S);
    localparam int RATE_SHIFT   = PROD_W + $clog2(SAMPLE_RATE);
    localparam int MUL1_W       = SINE_W + FIELD_W;
    localparam int MUL2_W       = MUL1_W + ENV_W;
    localparam int MUL_SHIFT    = 31;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [FIELD_W-1:0] RATE_U16    = FIELD_W'(SAMPLE_RATE);
    localparam logic [FIELD_W-1:0] GAIN_ONE    = FIELD_W'(32768);
    localparam logic [ENV_W-1:0]   ENV_ONE     = ENV_W'(65536);
    localparam logic [TABLE_BITS:0] TAB_N_U    = (TABLE_BITS + 1)'(TAB_N);
    localparam logic [IDX_W-1:0]   FADE_LEN_U  = IDX_W'(FADE_LEN);

    // Reciprocals that give exact floor quotients for any 32-bit dividend.
    localparam logic [RECIP_W-1:0] MS_RECIP   =
        RECIP_W'(((64'd1 << MS_SHIFT) / 64'(MS_PER_S)) + 64'd1);
    localparam logic [RECIP_W-1:0] RATE_RECIP =
        RECIP_W'(((64'd1 << RATE_SHIFT) / 64'(SAMPLE_RATE)) + 64'd1);

    // The phase step is freq * STEP_WHOLE plus freq * STEP_FRAC / SAMPLE_RATE.
    localparam logic [PHASE_W-1:0] STEP_WHOLE = PHASE_W'((64'd1 << PHASE_W) / 64'(SAMPLE_RATE));
    localparam logic [FIELD_W-1:0] STEP_FRAC  = FIELD_W'((64'd1 << PHASE_W) % 64'(SAMPLE_RATE));

    localparam logic [0:0] ACT_START = 1'b0;
    localparam logic [0:0] ACT_TICK  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ARGS  = 2'd1;
    localparam logic [1:0] STATUS_IDLE_TICK = 2'd2;

    localparam logic [7:0] TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

    typedef logic [SINE_W-1:0] sine_rom_t [0:TAB_N];
    typedef logic [ENV_W-1:0]  env_rom_t  [0:FADE_LEN-1];

    // Quarter-wave sine table from an eight-term Taylor series in Q2.30.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t r;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        logic signed [63:0] sum;
        for (int k = 0; k <= TAB_N; k++) begin
            x = (64'(k) * HALF_PI_Q30) >> TABLE_BITS;
            term = x;
            sum = signed'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / 64'(TAYLOR_DIV[n]);
                if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            r[k] = SINE_W'(v);
        end
        return r;
    endfunction

    // Fade ramp in Q0.16, one entry per sample of the ramp.
    function automatic env_rom_t build_env_rom();
        env_rom_t r;
        for (int d = 0; d < FADE_LEN; d++) begin
            r[d] = ENV_W'((64'(d) << 16) / FADE_LEN);
        end
        return r;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam env_rom_t  ENV_ROM  = build_env_rom();

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PROD,
        ST_COMMIT,
        ST_TICK_M1,
        ST_TICK_M2,
        ST_DONE
    } stg_state_t;

    typedef struct packed {
        logic capture;
        logic reject;
        logic tick_idle;
        logic prod;
        logic div_load;
        logic commit;
        logic tick_rd;
        logic tick_m1;
        logic tick_m2;
        logic load_out;
    } stg_cmd_t;

    typedef struct packed {
        logic [0:0] action;
        logic       args_bad;
        logic       tick_ok;
    } stg_sts_t;

endpackage

FILE: hw/rtl/stg_div.sv
// Division by 1000 and by the sample rate through reciprocal multiplies, one registered stage.
module stg_div (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [stg_pkg::PROD_W-1:0]  ms_numer,
    input  logic [stg_pkg::PROD_W-1:0]  rate_numer,
    output logic [stg_pkg::PROD_W-1:0]  ms_quot,
    output logic [stg_pkg::PROD_W-1:0]  rate_quot
);
    import stg_pkg::*;

    logic [RECIP_PROD_W-1:0] ms_prod;
    logic [RECIP_PROD_W-1:0] rate_prod;
    logic [PROD_W-1:0]       ms_quot_reg;
    logic [PROD_W-1:0]       rate_quot_reg;

    assign ms_prod   = RECIP_PROD_W'(ms_numer) * RECIP_PROD_W'(MS_RECIP);
    assign rate_prod = RECIP_PROD_W'(rate_numer) * RECIP_PROD_W'(RATE_RECIP);

    always_ff @(posedge aclk) begin
        if (load) begin
            ms_quot_reg   <= PROD_W'(ms_prod >> MS_SHIFT);
            rate_quot_reg <= PROD_W'(rate_prod >> RATE_SHIFT);
        end
    end

    assign ms_quot   = ms_quot_reg;
    assign rate_quot = rate_quot_reg;

endmodule

FILE: hw/rtl/stg_dp.sv
// Datapath: tone state, phase accumulator, sine and envelope lookup, gain multiplies.
module stg_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stg_pkg::stg_cmd_t           cmd,
    output stg_pkg::stg_sts_t           sts,
    input  logic [0:0]                  in_action,
    input  logic [stg_pkg::FIELD_W-1:0] in_freq,
    input  logic [stg_pkg::FIELD_W-1:0] in_ms,
    input  logic [stg_pkg::FIELD_W-1:0] in_vol,
    output logic [1:0]                  out_status,
    output logic [stg_pkg::FIELD_W-1:0] out_sample,
    output logic                        out_amp,
    output logic                        out_last
);
    import stg_pkg::*;

    logic [0:0]         act_reg;
    logic [FIELD_W-1:0] freq_reg, ms_reg, vol_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PHASE_W-1:0] step_whole_reg;
    logic [PROD_W-1:0]  step_rem_reg;

    logic [IDX_W-1:0]   sample_index_reg, sample_index_next;
    logic [IDX_W-1:0]   total_samples_reg, total_samples_next;
    logic [PHASE_W-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_W-1:0] phase_step_reg, phase_step_next;
    logic [FIELD_W-1:0] gain_q15_reg, gain_q15_next;
    logic               tone_active_reg, tone_active_next;

    logic [SINE_W-1:0]  mag_reg;
    logic               neg_reg;
    logic [ENV_W-1:0]   env_reg;
    logic [MUL1_W-1:0]  m1_reg;

    logic [1:0]         res_status_reg, res_status_next;
    logic [FIELD_W-1:0] res_sample_reg, res_sample_next;
    logic               res_amp_reg, res_amp_next;
    logic               res_last_reg, res_last_next;

    logic [1:0]         out_status_reg;
    logic [FIELD_W-1:0] out_sample_reg;
    logic               out_amp_reg;
    logic               out_last_reg;

    logic [PROD_W-1:0]  tot_quot;
    logic [PROD_W-1:0]  step_quot;

    logic [TABLE_BITS-1:0] tab_j;
    logic [TABLE_BITS:0]   tab_addr;
    logic [IDX_W-1:0]      tail_dist;
    logic [FADE_W-1:0]     env_idx;
    logic [ENV_W-1:0]      env_val;
    logic [MUL2_W-1:0]     m2;
    logic [FIELD_W-1:0]    mag_out;
    logic [IDX_W-1:0]      idx_inc;

    stg_div u_div (
        .aclk       (aclk),
        .load       (cmd.div_load),
        .ms_numer   (prod_reg),
        .rate_numer (step_rem_reg),
        .ms_quot    (tot_quot),
        .rate_quot  (step_quot)
    );

    assign tab_j    = phase_acc_reg[PHASE_W-3 -: TABLE_BITS];
    assign tab_addr = phase_acc_reg[PHASE_W-2] ? (TAB_N_U - {1'b0, tab_j}) : {1'b0, tab_j};

    assign tail_dist = total_samples_reg - sample_index_reg;

    always_comb begin
        env_idx = sample_index_reg[FADE_W-1:0];
        env_val = ENV_ONE;
        if (sample_index_reg < FADE_LEN_U) begin
            env_idx = sample_index_reg[FADE_W-1:0];
            env_val = ENV_ROM[env_idx];
        end else if ((total_samples_reg >= FADE_LEN_U) && (tail_dist < FADE_LEN_U)) begin
            env_idx = tail_dist[FADE_W-1:0];
            env_val = ENV_ROM[env_idx];
        end
    end

    assign m2      = MUL2_W'(m1_reg) * MUL2_W'(env_reg);
    assign mag_out = m2[MUL_SHIFT +: FIELD_W];
    assign idx_inc = sample_index_reg + IDX_W'(1);

    always_comb begin
        sample_index_next  = sample_index_reg;
        total_samples_next = total_samples_reg;
        phase_acc_next     = phase_acc_reg;
        phase_step_next    = phase_step_reg;
        gain_q15_next      = gain_q15_reg;
        tone_active_next   = tone_active_reg;
        res_status_next    = res_status_reg;
        res_sample_next    = res_sample_reg;
        res_amp_next       = res_amp_reg;
        res_last_next      = res_last_reg;
        if (cmd.reject) begin
            res_status_next = STATUS_BAD_ARGS;
            res_sample_next = '0;
            res_amp_next    = tone_active_reg;
            res_last_next   = 1'b0;
        end
        if (cmd.tick_idle) begin
            tone_active_next = 1'b0;
            res_status_next  = STATUS_IDLE_TICK;
            res_sample_next  = '0;
            res_amp_next     = 1'b0;
            res_last_next    = 1'b0;
        end
        if (cmd.commit) begin
            total_samples_next = tot_quot[IDX_W-1:0];
            phase_step_next    = step_whole_reg + step_quot;
            gain_q15_next      = (vol_reg > GAIN_ONE) ? GAIN_ONE : vol_reg;
            phase_acc_next     = '0;
            sample_index_next  = '0;
            tone_active_next   = tot_quot[IDX_W-1:0] != '0;
            res_status_next    = STATUS_OK;
            res_sample_next    = '0;
            res_amp_next       = tot_quot[IDX_W-1:0] != '0;
            res_last_next      = 1'b0;
        end
        if (cmd.tick_m2) begin
            phase_acc_next    = phase_acc_reg + phase_step_reg;
            sample_index_next = idx_inc;
            res_status_next   = STATUS_OK;
            res_sample_next   = neg_reg ? (FIELD_W'(0) - mag_out) : mag_out;
            res_amp_next      = 1'b1;
            res_last_next     = idx_inc >= total_samples_reg;
            if (idx_inc >= total_samples_reg) begin
                tone_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg  <= '0;
            total_samples_reg <= '0;
            phase_acc_reg     <= '0;
            phase_step_reg    <= '0;
            gain_q15_reg      <= '0;
            tone_active_reg   <= 1'b0;
        end else begin
            sample_index_reg  <= sample_index_next;
            total_samples_reg <= total_samples_next;
            phase_acc_reg     <= phase_acc_next;
            phase_step_reg    <= phase_step_next;
            gain_q15_reg      <= gain_q15_next;
            tone_active_reg   <= tone_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= in_action;
            freq_reg <= in_freq;
            ms_reg   <= in_ms;
            vol_reg  <= in_vol;
        end
        if (cmd.prod) begin
            prod_reg       <= PROD_W'(RATE_U16) * PROD_W'(ms_reg);
            step_whole_reg <= PHASE_W'(freq_reg) * STEP_WHOLE;
            step_rem_reg   <= PROD_W'(freq_reg) * PROD_W'(STEP_FRAC);
        end
        if (cmd.tick_rd) begin
            mag_reg <= SINE_ROM[tab_addr];
            neg_reg <= phase_acc_reg[PHASE_W-1];
            env_reg <= env_val;
        end
        if (cmd.tick_m1) begin
            m1_reg <= MUL1_W'(mag_reg) * MUL1_W'(gain_q15_reg);
        end
        res_status_reg <= res_status_next;
        res_sample_reg <= res_sample_next;
        res_amp_reg    <= res_amp_next;
        res_last_reg   <= res_last_next;
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_sample_reg <= res_sample_reg;
            out_amp_reg    <= res_amp_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign sts.action   = act_reg;
    assign sts.args_bad = (freq_reg == '0) || (ms_reg == '0);
    assign sts.tick_ok  = tone_active_reg && (sample_index_reg < total_samples_reg);

    assign out_status = out_status_reg;
    assign out_sample = out_sample_reg;
    assign out_amp    = out_amp_reg;
    assign out_last   = out_last_reg;

    a_active_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tone_active_reg |-> (sample_index_reg < total_samples_reg))
        else $error("active tone has no samples left");

    a_tick_on_active: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick_m2 |-> tone_active_reg)
        else $error("sample pipeline finished without an active tone");

    a_last_with_amp: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tick_m2 && (idx_inc >= total_samples_reg)) |=> (res_last_reg && res_amp_reg))
        else $error("final sample lost its flags");

endmodule

FILE: hw/rtl/stg_ctrl.sv
// Controller state machine: sequences start and tick items and the result register.
module stg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  stg_pkg::stg_sts_t  sts,
    output stg_pkg::stg_cmd_t  cmd
);
    import stg_pkg::*;

    stg_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.action == ACT_START) begin
                    state_next = sts.args_bad ? ST_DONE : ST_PROD;
                end else begin
                    state_next = sts.tick_ok ? ST_TICK_M1 : ST_DONE;
                end
            end
            ST_PROD: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                state_next = ST_DONE;
            end
            ST_TICK_M1: begin
                state_next = ST_TICK_M2;
            end
            ST_TICK_M2: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: begin
                if (sts.action == ACT_START) begin
                    cmd.reject = sts.args_bad;
                    cmd.prod   = !sts.args_bad;
                end else begin
                    cmd.tick_rd   = sts.tick_ok;
                    cmd.tick_idle = !sts.tick_ok;
                end
            end
            ST_PROD: begin
                cmd.div_load = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
            end
            ST_TICK_M1: begin
                cmd.tick_m1 = 1'b1;
            end
            ST_TICK_M2: begin
                cmd.tick_m2 = 1'b1;
            end
            ST_DONE: begin
                cmd.load_out = !out_valid_reg || m_tready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_load_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted item was not decoded");

    a_commit_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> ($past(state_reg) == ST_PROD))
        else $error("tone committed before the quotients were ready");

endmodule

FILE: hw/rtl/sine_tone_generator_with_fade_top.sv
// Top level of the sine tone generator with linear fade-in and fade-out.
//
//  Channel   Direction  tdata (low bit up)                   tuser    tlast
//  s_        in         tone_freq, duration_ms, volume       action   -
//  m_        out        sample, amplifier_on, zero pad       status   last_sample
//
// One item is worked on at a time; a new item is taken in the IDLE state only.
// A valid start passes through DECODE, PROD and COMMIT to DONE; a tick item through DECODE,
// TICK_M1 and TICK_M2 to DONE. The start forms its products in DECODE and its reciprocal
// multiplies in PROD. A rejected start or a tick while idle goes from DECODE to DONE.
// Reset is synchronous and leaves the block idle; a result that is not taken holds the
// next item in DONE and keeps s_tready low until the result register frees.
module sine_tone_generator_with_fade_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // tone_freq[15:0], duration_ms[31:16], volume[47:32]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample[15:0], amplifier_on[16], zero[23:17]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast    // last_sample
);
    import stg_pkg::*;

    stg_cmd_t           cmd;
    stg_sts_t           sts;
    logic [1:0]         out_status;
    logic [FIELD_W-1:0] out_sample;
    logic               out_amp;
    logic               out_last;

    stg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stg_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_action  (s_tuser),
        .in_freq    (s_tdata[15:0]),
        .in_ms      (s_tdata[31:16]),
        .in_vol     (s_tdata[47:32]),
        .out_status (out_status),
        .out_sample (out_sample),
        .out_amp    (out_amp),
        .out_last   (out_last)
    );

    assign m_tdata = {7'd0, out_amp, out_sample};
    assign m_tuser = out_status;
    assign m_tlast = out_last;

endmodule

FILE: sim/sine_tone_generator_with_fade_top_tb.sv
// Self-checking testbench for the sine tone generator with linear fade.
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0]  status;
    logic [15:0] sample;
    logic        amp_on;
    logic        last;
} tone_result_t;

class tone_scoreboard;
    int unsigned  sine_tab [stg_pkg::TAB_N + 1];
    logic [21:0]  sample_idx;
    logic [21:0]  total_cnt;
    logic [31:0]  phase;
    logic [31:0]  step;
    logic [15:0]  gain;
    bit           playing;
    tone_result_t pending_samples [$];
    int unsigned  mismatches;

    function new();
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        for (int k = 0; k <= stg_pkg::TAB_N; k++) begin
            x = (64'(k) * stg_pkg::HALF_PI_Q30) >> stg_pkg::TABLE_BITS;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            sine_tab[k] = int'(v);
        end
        sample_idx = '0;
        total_cnt  = '0;
        phase      = '0;
        step       = '0;
        gain       = '0;
        playing    = 1'b0;
        mismatches = 0;
    endfunction

    function void predict_sample(logic act, logic [15:0] freq, logic [15:0] ms,
                                 logic [15:0] vol);
        tone_result_t r;
        logic [1:0]   quad;
        int unsigned  j;
        int unsigned  mag_s;
        logic [31:0]  i32;
        logic [31:0]  tot32;
        logic [31:0]  env;
        logic [31:0]  fade;
        logic [63:0]  mag;
        logic [63:0]  num;
        r = '0;
        r.status = stg_pkg::STATUS_OK;
        fade = 32'(stg_pkg::FADE_LEN);
        if (act == stg_pkg::ACT_START) begin
            if (freq == 16'd0 || ms == 16'd0) begin
                r.status = stg_pkg::STATUS_BAD_ARGS;
                r.amp_on = playing;
            end else begin
                total_cnt  = 22'((32'(ms) * 32'(stg_pkg::SAMPLE_RATE)) / 32'd1000);
                gain       = (vol > stg_pkg::GAIN_ONE) ? stg_pkg::GAIN_ONE : vol;
                num        = {16'd0, freq, 32'd0};
                step       = 32'(num / 64'(stg_pkg::SAMPLE_RATE));
                phase      = '0;
                sample_idx = '0;
                playing    = (total_cnt != 22'd0);
                r.amp_on   = playing;
            end
        end else if (!playing || sample_idx >= total_cnt) begin
            playing  = 1'b0;
            r.status = stg_pkg::STATUS_IDLE_TICK;
        end else begin
            i32   = 32'(sample_idx);
            tot32 = 32'(total_cnt);
            quad  = phase[31:30];
            j     = int'((phase >> (30 - stg_pkg::TABLE_BITS)) & (stg_pkg::TAB_N - 1));
            mag_s = quad[0] ? sine_tab[stg_pkg::TAB_N - j] : sine_tab[j];
            if (i32 < fade) begin
                env = (i32 << 16) / fade;
            end else if (i32 > tot32 - fade) begin
                env = ((tot32 - i32) << 16) / fade;
            end else begin
                env = 32'd65536;
            end
            mag = (64'(mag_s) * 64'(gain) * 64'(env)) >> 31;
            r.sample = quad[1] ? 16'(-mag) : 16'(mag);
            phase = phase + step;
            sample_idx = 22'(i32 + 1);
            r.amp_on = 1'b1;
            if (i32 + 1 >= tot32) begin
                r.last  = 1'b1;
                playing = 1'b0;
            end
        end
        pending_samples.push_back(r);
    endfunction

    function void check_sample(logic [1:0] status, logic [15:0] sample, logic amp_on,
                               logic last);
        tone_result_t want;
        if (pending_samples.size() == 0) begin
            if (mismatches < 10) begin
                $display("%0t: result with nothing expected: status %0d sample %0d",
                         $realtime, status, $signed(sample));
            end
            mismatches++;
        end else begin
            want = pending_samples.pop_front();
            if (status !== want.status || sample !== want.sample ||
                amp_on !== want.amp_on || last !== want.last) begin
                if (mismatches < 10) begin
                    $display("%0t: mismatch: expected status %0d sample %0d amp %0d last %0d",
                             $realtime, want.status, $signed(want.sample), want.amp_on,
                             want.last);
                    $display("%0t:           got      status %0d sample %0d amp %0d last %0d",
                             $realtime, status, $signed(sample), amp_on, last);
                end
                mismatches++;
            end
        end
    endfunction

    function int unsigned pending();
        return pending_samples.size();
    endfunction
endclass

module sine_tone_generator_with_fade_top_tb;
    import stg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 900;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    tone_scoreboard sb;
    int unsigned    items_sent   = 0;
    int unsigned    burst_left   = 0;
    int unsigned    stall_cycles = 0;
    int unsigned    rx_cycle     = 0;
    rx_mode_t       rx_mode      = RX_OPEN;

    sine_tone_generator_with_fade_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_tready <= ($urandom_range(0, 1) == 0);
            end
            RX_PERIODIC: begin
                m_tready <= (rx_cycle % 7) < 4;
            end
            default: begin
                m_tready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_sample(m_tuser, m_tdata[15:0], m_tdata[16], m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input logic act, input logic [15:0] freq,
                             input logic [15:0] ms, input logic [15:0] vol);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vol, ms, freq};
        s_tuser  <= act;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.predict_sample(act, freq, ms, vol);
        burst_left--;
        items_sent++;
    endtask

    task automatic play_tone(input logic [15:0] freq, input logic [15:0] ms,
                             input logic [15:0] vol, input int unsigned ticks);
        send_item(ACT_START, freq, ms, vol);
        repeat (ticks) send_item(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] pick_volume();
        return ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(16384, 32768));
    endfunction

    function automatic logic [15:0] pick_freq();
        return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 4000))
                                           : 16'($urandom_range(1, 65535));
    endfunction

    initial begin
        int unsigned    kind;
        int unsigned    samples;
        logic [15:0]    ms;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ACT_START, 16'd0, 16'd100, 16'd32768);
        send_item(ACT_START, 16'd440, 16'd0, 16'd32768);
        play_tone(16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
        send_item(ACT_START, 16'd0, 16'd0, 16'd0);
        send_item(ACT_TICK, 16'd0, 16'd0, 16'd0);
        play_tone(16'd4000, 16'd1, 16'd32767, 16);
        send_item(ACT_TICK, 16'd0, 16'd0, 16'd0);

        while (items_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                case ($urandom_range(0, 2))
                    0: send_item(ACT_START, 16'd0, 16'($urandom), pick_volume());
                    1: send_item(ACT_START, pick_freq(), 16'd0, pick_volume());
                    default: send_item(ACT_START, 16'd0, 16'd0, 16'($urandom));
                endcase
                repeat ($urandom_range(0, 2)) send_item(ACT_TICK, 16'($urandom),
                                                        16'($urandom), 16'($urandom));
            end else if (kind < 55) begin
                ms = 16'($urandom_range(1, 6));
                samples = (int'(ms) * SAMPLE_RATE) / 1000;
                play_tone(pick_freq(), ms, pick_volume(), samples + $urandom_range(0, 2));
            end else if (kind < 70) begin
                ms = 16'($urandom_range(10, 13));
                samples = (int'(ms) * SAMPLE_RATE) / 1000;
                play_tone(pick_freq(), ms, pick_volume(), samples + $urandom_range(0, 1));
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 3)) send_item(ACT_TICK, 16'($urandom),
                                                        16'($urandom), 16'($urandom));
            end else begin
                play_tone(16'($urandom), 16'($urandom), 16'($urandom),
                          $urandom_range(0, 30));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/stg_pkg.sv
hw/rtl/stg_div.sv
hw/rtl/stg_dp.sv
hw/rtl/stg_ctrl.sv
hw/rtl/sine_tone_generator_with_fade_top.sv
sim/sine_tone_generator_with_fade_top_tb.sv
